[hdl/lfr_pkg.sv]
package lfr_pkg;

	// Sizes of the tables, the line chunk and the result run.
	localparam int MAX_PATTERN     = 32;
	localparam int MAX_REPLACEMENT = 32;
	localparam int LINE_CHUNK      = 1023;
	localparam int MAX_RESULTS     = 64;

	// Derived widths.
	localparam int IDX_W  = 5;
	localparam int CNT_W  = 6;
	localparam int TAB_AW = IDX_W + 1;
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);
	localparam int LPOS_W = $clog2(LINE_CHUNK + 1);
	localparam int CFG_AW = 4;

	localparam logic [7:0] NL_BYTE = 8'h0A;

	// Item function codes.
	localparam logic [1:0] FUNC_TEXT      = 2'd0;
	localparam logic [1:0] FUNC_LOAD_PAT  = 2'd1;
	localparam logic [1:0] FUNC_LOAD_REPL = 2'd2;
	localparam logic [1:0] FUNC_END       = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd0;
	localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd1;
	localparam logic [1:0] REG_GLOBAL_MODE        = 2'd2;

	// Table select bit, the top bit of the table address.
	localparam logic SEL_PATTERN     = 1'b0;
	localparam logic SEL_REPLACEMENT = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic [4:0] table_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_PLAN,
		ST_EMIT,
		ST_EMIT_LD
	} state_t;

	typedef enum logic [1:0] {
		PH_KEEP,
		PH_REPL,
		PH_FLUSH
	} phase_t;

	// Control from the sequencer to the shared compare unit.
	typedef struct packed {
		logic             start;
		logic             cmp_en;
		logic [IDX_W-1:0] cmp_idx;
		logic             commit;
		logic             clear;
	} mu_ctl_t;

endpackage

[hdl/lfr_table.sv]
module lfr_table
	import lfr_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [TAB_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [TAB_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	// Pattern bytes in the lower half, replacement bytes in the upper half.
	logic [7:0] mem [2**TAB_AW];
	logic [7:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/lfr_match.sv]
module lfr_match
	import lfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mu_ctl_t          ctl,
	input  logic [7:0]       text_byte,
	input  logic [7:0]       pat_byte,
	output logic [CNT_W-1:0] match_len
);

	// Bit j of active_q is set when the last j+1 held bytes equal the
	// first j+1 pattern bytes.
	logic [MAX_PATTERN-1:0] active_q;
	logic [MAX_PATTERN-1:0] next_q;
	logic [CNT_W-1:0]       len_q;
	logic                   cmp_en_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic                   prev_bit;
	logic                   hit;

	// One byte compare per cycle against the pattern byte just read.
	always_comb begin
		if (cmp_idx_s1 == '0) begin
			prev_bit = 1'b1;
		end else begin
			prev_bit = active_q[cmp_idx_s1 - IDX_W'(1)];
		end
		hit = cmp_en_s1 && prev_bit && (pat_byte == text_byte);
	end

	// Compare request is registered so that it meets the table data in the cycle after the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= ctl.cmp_en;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= ctl.cmp_idx;
	end

	// Build the next prefix vector; the last hit gives the longest prefix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			len_q  <= '0;
		end else if (ctl.start) begin
			next_q <= '0;
			len_q  <= '0;
		end else if (hit) begin
			next_q[cmp_idx_s1] <= 1'b1;
			len_q              <= {1'b0, cmp_idx_s1} + CNT_W'(1);
		end
	end

	// Held prefix vector, updated once per compared text item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (ctl.clear) begin
			active_q <= '0;
		end else if (ctl.commit) begin
			active_q <= next_q;
		end
	end

	assign match_len = len_q;

endmodule

[hdl/literal_find_replace_stream_unit.sv]
// Timing: a searched text byte is accepted in the idle state, then compared in the scan and
// scan end states, reading one pattern byte per cycle from the table memory, then planned.
// Each result passes the emit and load states, with phase steps and a closing emit state.
// End items and text bytes after a single-mode match skip the compare cycles.
// Flow: a load item leaves the block idle for the next item. Any other item holds cmd_ready
// low until its closing emit state; a result waiting on res_ready stalls the sequencer
// until taken. Reset clears control state and registers; tables are undefined until loaded.
module literal_find_replace_stream_unit
	import lfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  k_q, k_d;
	logic [RES_W-1:0]  rem_q, rem_d;
	logic              from_c_q, from_c_d;
	logic [CNT_W-1:0]  lim_a_q, lim_b_q, lim_c_q, a_src_q;
	logic [CNT_W-1:0]  held_q;
	logic              changed_q;
	logic [LPOS_W-1:0] pos_q;
	logic [1:0]        func_q;
	logic [7:0]        byte_q;
	logic [CNT_W-1:0]  plen_q, rlen_q;
	logic              global_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              cmd_fire;
	logic              cfg_wr;
	logic              out_free;
	logic              load_out;
	logic [CNT_W-1:0]  eff_plen, eff_rlen;
	logic [CNT_W-1:0]  cur_lim;
	logic [TAB_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              ram_we;
	logic [CNT_W-1:0]  match_len;
	mu_ctl_t           mu_ctl;

	// Plan terms for the item in hand.
	logic              is_text, bypass, do_flush, is_match;
	logic [LPOS_W:0]   pos_next;
	logic [CNT_W-1:0]  a_cnt, b_cnt, c_cnt, new_held, a_src;
	logic [RES_W-1:0]  total_cnt;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || res_ready;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= CNT_W'(1);
			rlen_q   <= '0;
			global_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PATTERN_LENGTH:     plen_q   <= pwdata[CNT_W-1:0];
				REG_REPLACEMENT_LENGTH: rlen_q   <= pwdata[CNT_W-1:0];
				REG_GLOBAL_MODE:        global_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PATTERN_LENGTH:     prdata = {{(32-CNT_W){1'b0}}, plen_q};
			REG_REPLACEMENT_LENGTH: prdata = {{(32-CNT_W){1'b0}}, rlen_q};
			REG_GLOBAL_MODE:        prdata = {31'd0, global_q};
			default:                prdata = '0;
		endcase
	end

	// Lengths saturated to the table sizes; a zero pattern length acts as one.
	always_comb begin
		if (plen_q == '0) begin
			eff_plen = CNT_W'(1);
		end else if (plen_q > CNT_W'(MAX_PATTERN)) begin
			eff_plen = CNT_W'(MAX_PATTERN);
		end else begin
			eff_plen = plen_q;
		end
		if (rlen_q > CNT_W'(MAX_REPLACEMENT)) begin
			eff_rlen = CNT_W'(MAX_REPLACEMENT);
		end else begin
			eff_rlen = rlen_q;
		end
	end

	// Table loads are taken only while no bytes are held.
	assign ram_we = cmd_fire && (cmd.func inside {FUNC_LOAD_PAT, FUNC_LOAD_REPL})
		&& (held_q == '0);

	lfr_table u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({cmd.func == FUNC_LOAD_REPL, cmd.table_index}),
		.wdata (cmd.data_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lfr_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mu_ctl),
		.text_byte (byte_q),
		.pat_byte  (ram_rdata),
		.match_len (match_len)
	);

	// Work out what the item emits: kept bytes, replacement, then flushed bytes.
	always_comb begin
		is_text  = (func_q == FUNC_TEXT);
		bypass   = is_text && changed_q && !global_q;
		pos_next = {1'b0, pos_q} + (LPOS_W+1)'(1);
		do_flush = !is_text || (byte_q == NL_BYTE) || (pos_next >= (LPOS_W+1)'(LINE_CHUNK));
		is_match = is_text && !bypass && (match_len == eff_plen);
		if (!is_text) begin
			a_cnt = '0;
		end else if (bypass) begin
			a_cnt = CNT_W'(1);
		end else begin
			a_cnt = held_q + CNT_W'(1) - match_len;
		end
		a_src = bypass ? '0 : held_q;
		b_cnt = is_match ? eff_rlen : '0;
		if (!is_text || bypass) begin
			new_held = held_q;
		end else if (is_match) begin
			new_held = '0;
		end else begin
			new_held = match_len;
		end
		c_cnt     = do_flush ? new_held : '0;
		total_cnt = RES_W'(a_cnt) + RES_W'(b_cnt) + RES_W'(c_cnt);
	end

	// Limit of the phase being emitted.
	always_comb begin
		case (phase_q)
			PH_KEEP:  cur_lim = lim_a_q;
			PH_REPL:  cur_lim = lim_b_q;
			PH_FLUSH: cur_lim = lim_c_q;
			default:  cur_lim = '0;
		endcase
	end

	// Sequencer state register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_KEEP;
			k_q      <= '0;
			rem_q    <= '0;
			from_c_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			k_q      <= k_d;
			rem_q    <= rem_d;
			from_c_q <= from_c_d;
		end
	end

	// Next state, table address and compare unit control.
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		k_d       = k_q;
		rem_d     = rem_q;
		from_c_d  = from_c_q;
		load_out  = 1'b0;
		ram_raddr = {SEL_PATTERN, k_q[IDX_W-1:0]};
		mu_ctl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					k_d = '0;
					if (cmd.func == FUNC_TEXT && !(changed_q && !global_q)) begin
						mu_ctl.start = 1'b1;
						state_d      = ST_SCAN;
					end else if (cmd.func == FUNC_TEXT || cmd.func == FUNC_END) begin
						state_d = ST_PLAN;
					end
				end
			end
			ST_SCAN: begin
				mu_ctl.cmp_en  = 1'b1;
				mu_ctl.cmp_idx = k_q[IDX_W-1:0];
				k_d            = k_q + CNT_W'(1);
				if (k_q == eff_plen - CNT_W'(1)) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				mu_ctl.clear  = do_flush || is_match;
				mu_ctl.commit = is_text && !bypass;
				rem_d         = total_cnt;
				phase_d       = PH_KEEP;
				k_d           = '0;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				if (rem_q == '0) begin
					state_d = ST_IDLE;
				end else if (k_q == cur_lim) begin
					k_d = '0;
					case (phase_q)
						PH_KEEP: phase_d = PH_REPL;
						default: phase_d = PH_FLUSH;
					endcase
				end else if (out_free) begin
					ram_raddr = {(phase_q == PH_REPL) ? SEL_REPLACEMENT : SEL_PATTERN,
						k_q[IDX_W-1:0]};
					from_c_d  = (phase_q == PH_KEEP) && (k_q == a_src_q);
					k_d       = k_q + CNT_W'(1);
					state_d   = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				load_out = 1'b1;
				rem_d    = rem_q - RES_W'(1);
				state_d  = ST_EMIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Item payload latched on accept.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			func_q <= cmd.func;
			byte_q <= cmd.data_byte;
		end
	end

	// Line state and emission limits, set in the plan cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			changed_q <= 1'b0;
			pos_q     <= '0;
			lim_a_q   <= '0;
			lim_b_q   <= '0;
			lim_c_q   <= '0;
			a_src_q   <= '0;
		end else if (state_q == ST_PLAN) begin
			lim_a_q <= a_cnt;
			lim_b_q <= b_cnt;
			lim_c_q <= c_cnt;
			a_src_q <= a_src;
			if (do_flush) begin
				held_q    <= '0;
				changed_q <= 1'b0;
				pos_q     <= '0;
			end else begin
				held_q    <= new_held;
				changed_q <= changed_q || is_match;
				pos_q     <= pos_next[LPOS_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_byte <= from_c_q ? byte_q : ram_rdata;
			out_q.last     <= (rem_q == RES_W'(1));
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

`ifndef ASSERT_OFF
	// A held prefix is always shorter than the longest pattern.
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < CNT_W'(MAX_PATTERN))
		else $error("held prefix count out of range");

	// The output register is free whenever a result is loaded.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> !out_valid_q)
		else $error("result loaded over a waiting result");

	// A result is loaded only while results remain for the item.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> rem_q != '0)
		else $error("result loaded with none remaining");

	// The block takes a new item only after all results were loaded.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> rem_q == '0)
		else $error("idle with results outstanding");

	// The final result of an item is followed by a return to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && rem_q == RES_W'(1) |=> ##1 state_q == ST_IDLE)
		else $error("no return to idle after the final result");
`endif

endmodule

[test/literal_find_replace_stream_unit_tb.sv]
`timescale 1ns / 100ps

module literal_find_replace_stream_unit_tb;
	import lfr_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS   = 24;

	// Tracks the edit state of the stream and the output bytes still owed by the block.
	class replace_scoreboard;
		logic [7:0] pat_tab[MAX_PATTERN];
		logic [7:0] repl_tab[MAX_REPLACEMENT];
		logic [5:0] plen_reg;
		logic [5:0] rlen_reg;
		bit         global_reg;
		int         held;
		int         line_pos;
		bit         line_changed;
		logic [7:0] run[$];
		res_t       pending_bytes[$];
		int         failures;
		int         bytes_checked;
		int         items_noted;
		int         replacements;
		int         line_ends;
		int         chunk_flushes;

		function new();
			plen_reg = 6'd1;
			rlen_reg = 6'd0;
			global_reg = 1'b0;
			held = 0;
			line_pos = 0;
			line_changed = 1'b0;
		endfunction

		function int eff_plen();
			if (plen_reg == 0)
				return 1;
			return (plen_reg > MAX_PATTERN) ? MAX_PATTERN : int'(plen_reg);
		endfunction

		function int eff_rlen();
			return (rlen_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rlen_reg);
		endfunction

		function void set_reg(logic [1:0] idx, logic [5:0] value);
			case (idx)
				REG_PATTERN_LENGTH:     plen_reg = value;
				REG_REPLACEMENT_LENGTH: rlen_reg = value;
				REG_GLOBAL_MODE:        global_reg = value[0];
				default: ;
			endcase
		endfunction

		// Release the held prefix and clear the line state.
		function void flush_line();
			for (int k = 0; k < held && k < MAX_PATTERN; k++)
				run.push_back(pat_tab[k]);
			held = 0;
			line_changed = 1'b0;
			line_pos = 0;
			line_ends++;
		endfunction

		// Find the longest suffix of held bytes plus the new byte that still matches
		// the pattern start; everything in front of it is released.
		function void scan_byte(logic [7:0] c);
			logic [7:0] window[MAX_PATTERN + 1];
			int plen, h, total, i, k, len_match;
			bit ok;
			if (line_changed && !global_reg) begin
				run.push_back(c);
				return;
			end
			plen = eff_plen();
			h = (held > MAX_PATTERN - 1) ? MAX_PATTERN - 1 : held;
			for (k = 0; k < h; k++)
				window[k] = pat_tab[k];
			window[h] = c;
			total = h + 1;
			len_match = 0;
			for (i = 0; i <= total; i++) begin
				len_match = total - i;
				if (len_match > plen)
					continue;
				ok = 1'b1;
				for (k = 0; k < len_match; k++) begin
					if (window[i + k] != pat_tab[k]) begin
						ok = 1'b0;
						break;
					end
				end
				if (ok)
					break;
			end
			for (k = 0; k < i && k < total; k++)
				run.push_back(window[k]);
			if (len_match == plen) begin
				for (k = 0; k < eff_rlen(); k++)
					run.push_back(repl_tab[k]);
				held = 0;
				line_changed = 1'b1;
				replacements++;
			end else begin
				held = len_match;
			end
		endfunction

		// Called for every accepted item; queues the bytes it must produce.
		function void note_item(cmd_t c);
			res_t r;
			run.delete();
			items_noted++;
			case (c.func)
				FUNC_LOAD_PAT: begin
					if (held == 0)
						pat_tab[c.table_index] = c.data_byte;
				end
				FUNC_LOAD_REPL: begin
					if (held == 0)
						repl_tab[c.table_index] = c.data_byte;
				end
				FUNC_END: flush_line();
				default: begin
					scan_byte(c.data_byte);
					line_pos++;
					if (c.data_byte == NL_BYTE || line_pos >= LINE_CHUNK) begin
						if (c.data_byte != NL_BYTE)
							chunk_flushes++;
						flush_line();
					end
				end
			endcase
			for (int k = 0; k < run.size() && k < MAX_RESULTS; k++) begin
				r.out_byte = run[k];
				r.last = (k == run.size() - 1 || k == MAX_RESULTS - 1);
				pending_bytes.push_back(r);
			end
		endfunction

		// Compares one output byte with the oldest one owed.
		function void check_byte(res_t got);
			res_t want;
			if (pending_bytes.size() == 0) begin
				failures++;
				$error("unexpected output byte %02h (last %0b)", got.out_byte, got.last);
				return;
			end
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (got.out_byte !== want.out_byte) begin
				failures++;
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
			end
			if (got.last !== want.last) begin
				failures++;
				$error("last: expected %0b, got %0b", want.last, got.last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	replace_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int settings_done;

	literal_find_replace_stream_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#8000000;
		$display("literal_find_replace_stream_unit_tb: FAIL");
		$finish;
	end

	// Output side: check each accepted byte and stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready)
				sb.check_byte(res);
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic cmd_t make_item(logic [1:0] f, logic [7:0] d, logic [4:0] idx);
		cmd_t c;
		c.func = f;
		c.data_byte = d;
		c.table_index = idx;
		return c;
	endfunction

	// Mostly the two letters the patterns are built from, so matches stay common.
	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return "a";
		if (r < 9)
			return "b";
		return 8'($urandom_range(255));
	endfunction

	// Offers one item and holds it until the block takes it.
	task automatic send_item(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		sb.note_item(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(make_item(FUNC_TEXT, s[i], 5'($urandom_range(31))));
	endtask

	// Sender stops until every owed byte has come out.
	task automatic wait_results_done();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_bytes.size() != 0);
	endtask

	// Register writes happen only with the stream quiet, including any held-prefix search.
	task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {26'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	// One random burst: pattern copies, partial prefixes, loose bytes, line ends and loads.
	task automatic send_random_chunk(input bit allow_breaks, output int sent);
		int pick, plen, n;
		logic [7:0] b;
		pick = $urandom_range(99);
		plen = sb.eff_plen();
		sent = 0;
		if (pick < 68) begin
			n = (pick < 50 || plen == 1) ? plen : $urandom_range(1, plen - 1);
			for (int k = 0; k < n; k++) begin
				b = sb.pat_tab[k];
				if (!allow_breaks && b == NL_BYTE)
					b = "a";
				send_item(make_item(FUNC_TEXT, b, 5'($urandom_range(31))));
				sent++;
			end
		end else if (pick < 93) begin
			if (pick < 83)
				b = pick_alpha();
			else if (pick < 88)
				b = allow_breaks ? NL_BYTE : pick_alpha();
			else
				b = 8'($urandom_range(255));
			if (!allow_breaks && b == NL_BYTE)
				b = "b";
			send_item(make_item(FUNC_TEXT, b, 5'($urandom_range(31))));
			sent = 1;
		end else if (pick < 96 && allow_breaks) begin
			send_item(make_item(FUNC_END, 8'($urandom_range(255)), 5'($urandom_range(31))));
			sent = 1;
		end else if ($urandom_range(1) == 0) begin
			send_item(make_item(FUNC_LOAD_PAT, pick_alpha(), 5'($urandom_range(31))));
			sent = 1;
		end else begin
			send_item(make_item(FUNC_LOAD_REPL, 8'($urandom_range(255)),
				5'($urandom_range(31))));
			sent = 1;
		end
	endtask

	// Register settings per slot; the extremes come first, and slots without a fixed value take random ones.
	function automatic logic [5:0] pick_plen(int s);
		case (s)
			0: return 6'd0;
			1: return 6'd32;
			2: return 6'd63;
			3: return 6'd2;
			4: return 6'd1;
			6: return 6'd4;
			7: return 6'd33;
			default: return 6'($urandom_range(1, 32));
		endcase
	endfunction

	function automatic logic [5:0] pick_rlen(int s);
		case (s)
			0: return 6'd32;
			1: return 6'd0;
			2: return 6'd63;
			3: return 6'd1;
			4: return 6'd5;
			6: return 6'd33;
			7: return 6'd0;
			default: return 6'($urandom_range(0, 32));
		endcase
	endfunction

	// Main sequence.
	initial begin
		int sent, total, setting;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 22;
		recv_idle_pct = 77;
		settings_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both tables so no unwritten entry is ever read; the pattern starts "aab".
		for (int k = 0; k < MAX_PATTERN; k++)
			send_item(make_item(FUNC_LOAD_PAT, (k < 2) ? 8'h61 : (k == 2) ? 8'h62 : pick_alpha(),
				5'(k)));
		for (int k = 0; k < MAX_REPLACEMENT; k++)
			send_item(make_item(FUNC_LOAD_REPL, 8'($urandom_range(255)), 5'(k)));

		write_reg(REG_PATTERN_LENGTH, 6'd3);
		write_reg(REG_REPLACEMENT_LENGTH, 6'd2);
		write_reg(REG_GLOBAL_MODE, 6'd0);
		settings_done++;

		// Directed: a released prefix before a match, a second match left alone in
		// single mode, extreme byte values, loads refused while bytes are held, end of
		// input with and without held bytes, and a length change over a held prefix.
		send_text("aaab\n");
		send_text("aabaab\n");
		send_item(make_item(FUNC_TEXT, 8'h00, 5'd0));
		send_item(make_item(FUNC_TEXT, 8'hFF, 5'd31));
		send_text("a");
		send_item(make_item(FUNC_LOAD_PAT, 8'hFF, 5'd31));
		send_item(make_item(FUNC_LOAD_REPL, 8'hFF, 5'd0));
		send_item(make_item(FUNC_END, 8'hFF, 5'd31));
		send_item(make_item(FUNC_END, 8'h00, 5'd0));
		send_text("aa");
		write_reg(REG_PATTERN_LENGTH, 6'd1);
		settings_done++;
		send_text("b\n");

		// Random part over three idling mixes, three register settings in each.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 77 : 0;
			recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 22 : 0;
			for (int slot = 0; slot < 3; slot++) begin
				setting = phase * 3 + slot;
				write_reg(REG_PATTERN_LENGTH, pick_plen(setting));
				write_reg(REG_REPLACEMENT_LENGTH, pick_rlen(setting));
				write_reg(REG_GLOBAL_MODE,
					6'((setting == 8) ? $urandom_range(1) : setting % 2));
				settings_done++;
				total = 0;
				while (total < PHASE_ITEMS) begin
					if ($urandom_range(39) == 0)
						wait_results_done();
					send_random_chunk(1'b1, sent);
					total += sent;
				end
			end
		end

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d output bytes, with %0d replacements,",
			sb.items_noted, sb.bytes_checked, sb.replacements);
		$display("%0d line ends (%0d at the length limit) over %0d register settings.",
			sb.line_ends, sb.chunk_flushes, settings_done);
		if (sb.failures == 0 && sb.pending_bytes.size() == 0) begin
			$display("literal_find_replace_stream_unit_tb: PASS");
		end else begin
			$display("literal_find_replace_stream_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

[files.f]
hdl/lfr_pkg.sv
hdl/lfr_table.sv
hdl/lfr_match.sv
hdl/literal_find_replace_stream_unit.sv
test/literal_find_replace_stream_unit_tb.sv
